[rtl/hkd_pkg.sv]
// hkd_pkg: shared types and constants for the heatmap keypoint decoder
// used by hkd_map and heatmap_keypoint_decode; no dependencies
package hkd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 18;
  localparam int DIM_W      = 8;
  localparam int COORD_W    = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CMP_W      = DIM_W + 1;

  localparam int POS_MAX = 131071;
  localparam int POS_MIN = -131072;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  localparam logic [DIM_W-1:0]   MAP_WIDTH_RST  = 8'd72;
  localparam logic [DIM_W-1:0]   MAP_HEIGHT_RST = 8'd96;
  localparam logic [COORD_W-1:0] CENTER_X_RST   = 12'd144;
  localparam logic [COORD_W-1:0] CENTER_Y_RST   = 12'd192;
  localparam logic [COORD_W-1:0] BOX_WIDTH_RST  = 12'd288;
  localparam logic [COORD_W-1:0] BOX_HEIGHT_RST = 12'd384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 3'd0,
    CFG_MAP_HEIGHT = 3'd1,
    CFG_CENTER_X   = 3'd2,
    CFG_CENTER_Y   = 3'd3,
    CFG_BOX_WIDTH  = 3'd4,
    CFG_BOX_HEIGHT = 3'd5
  } hkd_cfg_e;

  typedef enum logic [3:0] {
    S_SCAN  = 4'b0001,
    S_READ  = 4'b0010,
    S_START = 4'b0100,
    S_WAIT  = 4'b1000
  } hkd_state_e;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_MUL  = 4'b0010,
    M_DIV  = 4'b0100,
    M_FIN  = 4'b1000
  } hkd_map_state_e;

endpackage

[rtl/hkd_ram.sv]
// hkd_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module hkd_ram #(
  parameter int Width = 16,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hkd_map.sv]
// hkd_map: maps a quarter-pixel heatmap position to image space in Q4
// multiplier, bit-serial floor divider and saturation; uses hkd_pkg
module hkd_map #(
  parameter int PosW = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [PosW-1:0]              pos_i,
  input  logic [hkd_pkg::COORD_W-1:0]         box_i,
  input  logic [hkd_pkg::COORD_W-1:0]         centre_i,
  input  logic [hkd_pkg::DIM_W-1:0]           dim_i,
  output logic                                done_o,
  output logic signed [hkd_pkg::POS_W-1:0]    result_o
);
  import hkd_pkg::*;

  localparam int ProdW = PosW + COORD_W + 1;
  localparam int NumW  = PosW + 17;
  localparam int MagW  = NumW - 1;
  localparam int RemW  = DIM_W + 1;
  localparam int CntW  = $clog2(MagW);
  localparam int SumW  = MagW + 2;

  hkd_map_state_e state_q, state_d;

  logic signed [ProdW-1:0] prod_q;
  logic signed [NumW-1:0]  num;
  logic [MagW-1:0]         mag;
  logic [MagW-1:0]         quo_q;
  logic [RemW-1:0]         rem_q;
  logic [RemW-1:0]         divisor;
  logic [RemW:0]           rem_sh;
  logic                    rem_ge;
  logic [RemW-1:0]         rem_nx;
  logic [CntW-1:0]         cnt_q;
  logic                    neg_q;
  logic                    done_q;
  logic signed [POS_W-1:0] result_q;
  logic signed [SumW-1:0]  qu_s, q_s, sum_s;
  logic signed [POS_W-1:0] sat;

  assign num     = (NumW'(prod_q) <<< 3) + NumW'($signed({1'b0, dim_i}));
  assign mag     = num[NumW-1] ? MagW'(-num) : MagW'(num);
  assign divisor = {dim_i, 1'b0};

  // restoring step, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[MagW-1]};
  assign rem_ge = rem_sh >= {1'b0, divisor};
  assign rem_nx = rem_ge ? RemW'(rem_sh - {1'b0, divisor}) : RemW'(rem_sh);

  // floor division for negative numerators rounds the magnitude up
  always_comb begin
    qu_s  = signed'(SumW'(quo_q));
    q_s   = neg_q ? -(qu_s + signed'(SumW'(rem_q != '0))) : qu_s;
    sum_s = q_s + signed'(SumW'({centre_i, 4'b0000})) - signed'(SumW'({box_i, 3'b000}));
    if (sum_s > SumW'(POS_MAX)) begin
      sat = POS_W'(POS_MAX);
    end else if (sum_s < SumW'(POS_MIN)) begin
      sat = POS_W'(POS_MIN);
    end else begin
      sat = POS_W'(sum_s);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      M_IDLE: if (start_i) state_d = M_MUL;
      M_MUL:  state_d = M_DIV;
      M_DIV:  if (cnt_q == CntW'(MagW - 1)) state_d = M_FIN;
      M_FIN:  state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == M_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (start_i) prod_q <= ProdW'(pos_i) * ProdW'($signed({1'b0, box_i}));
      end
      M_MUL: begin
        neg_q <= num[NumW-1];
        quo_q <= mag;
        rem_q <= '0;
        cnt_q <= '0;
      end
      M_DIV: begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[MagW-2:0], rem_ge};
        cnt_q <= cnt_q + CntW'(1);
      end
      M_FIN: result_q <= sat;
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

[rtl/heatmap_keypoint_decode.sv]
// heatmap_keypoint_decode: argmax keypoint decoder with quarter-pixel refinement
// samples are accepted one per cycle while busy_o is low; after the last sample the
// block stays busy for four neighbor reads from the map ram, then maps x and y each
// through the shared serial divider at one quotient bit per cycle; done_o pulses for
// one cycle and cannot be stalled
// async active-low reset restores the register defaults; the map ram is not cleared
module heatmap_keypoint_decode #(
  parameter int MAX_MAP_WIDTH  = 128,
  parameter int MAX_MAP_HEIGHT = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [hkd_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 last_i,
  input  logic                                 cfg_we_i,
  input  logic [hkd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [hkd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic                                 done_o,
  output logic signed [hkd_pkg::POS_W-1:0]     x_position_o,
  output logic signed [hkd_pkg::POS_W-1:0]     y_position_o,
  output logic signed [hkd_pkg::SAMPLE_W-1:0]  score_o,
  output logic                                 found_o
);
  import hkd_pkg::*;

  localparam int Depth = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
  localparam int AddrW = $clog2(Depth);
  localparam int ColW  = $clog2(MAX_MAP_WIDTH);
  localparam int RowW  = $clog2(MAX_MAP_HEIGHT);
  localparam int PosW  = ((ColW > RowW) ? ColW : RowW) + 3;

  // configuration
  logic [DIM_W-1:0]   map_width_q, map_height_q;
  logic [COORD_W-1:0] center_x_q, center_y_q, box_width_q, box_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
      center_x_q   <= CENTER_X_RST;
      center_y_q   <= CENTER_Y_RST;
      box_width_q  <= BOX_WIDTH_RST;
      box_height_q <= BOX_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_MAP_HEIGHT: map_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_CENTER_X:   center_x_q   <= cfg_data_i;
        CFG_CENTER_Y:   center_y_q   <= cfg_data_i;
        CFG_BOX_WIDTH:  box_width_q  <= cfg_data_i;
        CFG_BOX_HEIGHT: box_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff, h_eff;

  always_comb begin
    if (map_width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (int'(map_width_q) > MAX_MAP_WIDTH) begin
      w_eff = DIM_W'(MAX_MAP_WIDTH);
    end else begin
      w_eff = map_width_q;
    end
    if (map_height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (int'(map_height_q) > MAX_MAP_HEIGHT) begin
      h_eff = DIM_W'(MAX_MAP_HEIGHT);
    end else begin
      h_eff = map_height_q;
    end
  end

  // scan state
  hkd_state_e state_q;
  logic accept;

  logic [ColW-1:0]            col_q, col_d, col_eff, best_col_q;
  logic [RowW-1:0]            row_q, row_d, row_eff, best_row_q;
  logic signed [SAMPLE_W-1:0] best_q;
  logic [CMP_W-1:0]           col_inc, row_inc;

  assign busy_o = (state_q != S_SCAN);
  assign accept = start_i && !busy_o;

  always_comb begin
    // a shrunken map size pulls stale counters back to zero
    col_eff = (CMP_W'(col_q) >= CMP_W'(w_eff)) ? '0 : col_q;
    row_eff = (CMP_W'(row_q) >= CMP_W'(h_eff)) ? '0 : row_q;
    col_inc = CMP_W'(col_eff) + CMP_W'(1);
    row_inc = CMP_W'(row_eff) + CMP_W'(1);
    if (col_inc >= CMP_W'(w_eff)) begin
      col_d = '0;
      row_d = (row_inc >= CMP_W'(h_eff)) ? '0 : RowW'(row_inc);
    end else begin
      col_d = ColW'(col_inc);
      row_d = row_eff;
    end
  end

  // map ram
  logic [AddrW-1:0]    waddr, raddr, base;
  logic [SAMPLE_W-1:0] rdata;
  logic [2:0]          rd_cnt_q;

  assign waddr = AddrW'(row_eff) * AddrW'(MAX_MAP_WIDTH) + AddrW'(col_eff);
  assign base  = AddrW'(best_row_q) * AddrW'(MAX_MAP_WIDTH) + AddrW'(best_col_q);

  // neighbor order: right, left, below, above
  always_comb begin
    case (rd_cnt_q)
      3'd0:    raddr = base + AddrW'(1);
      3'd1:    raddr = base - AddrW'(1);
      3'd2:    raddr = base + AddrW'(MAX_MAP_WIDTH);
      default: raddr = base - AddrW'(MAX_MAP_WIDTH);
    endcase
  end

  hkd_ram #(
    .Width(SAMPLE_W),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(waddr),
    .wdata_i(sample_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic signed [SAMPLE_W-1:0] nb_q [4];

  // peak position in quarter pixels
  logic                   found, refine;
  logic signed [PosW-1:0] dx, dy, px, py;

  assign found  = best_q > 0;
  assign refine = found
               && (CMP_W'(best_col_q) > CMP_W'(1))
               && (CMP_W'(best_col_q) + CMP_W'(1) < CMP_W'(w_eff))
               && (CMP_W'(best_row_q) > CMP_W'(1))
               && (CMP_W'(best_row_q) + CMP_W'(1) < CMP_W'(h_eff));

  always_comb begin
    dx = PosW'(0);
    dy = PosW'(0);
    if (refine) begin
      if (nb_q[3] > nb_q[2]) dx = PosW'(1);
      else if (nb_q[3] < nb_q[2]) dx = PosW'(-1);
      if (nb_q[1] > nb_q[0]) dy = PosW'(1);
      else if (nb_q[1] < nb_q[0]) dy = PosW'(-1);
    end
    px = found ? signed'(PosW'({best_col_q, 2'b00})) + dx : PosW'(-4);
    py = found ? signed'(PosW'({best_row_q, 2'b00})) + dy : PosW'(-4);
  end

  // image mapping, x then y through one unit
  logic                    axis_q;
  logic                    map_done;
  logic signed [POS_W-1:0] map_res;

  hkd_map #(
    .PosW(PosW)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_START),
    .pos_i   (axis_q ? py : px),
    .box_i   (axis_q ? box_height_q : box_width_q),
    .centre_i(axis_q ? center_y_q : center_x_q),
    .dim_i   (axis_q ? h_eff : w_eff),
    .done_o  (map_done),
    .result_o(map_res)
  );

  logic                       done_q, found_q;
  logic signed [POS_W-1:0]    x_q, y_q;
  logic signed [SAMPLE_W-1:0] score_q;
  logic                       emit;

  assign emit = (state_q == S_WAIT) && map_done && axis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_SCAN;
      col_q      <= '0;
      row_q      <= '0;
      best_q     <= SAMPLE_MIN;
      best_col_q <= '0;
      best_row_q <= '0;
      rd_cnt_q   <= '0;
      axis_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= emit;
      case (state_q)
        S_SCAN: begin
          if (accept) begin
            col_q <= col_d;
            row_q <= row_d;
            if (sample_i > best_q) begin
              best_q     <= sample_i;
              best_col_q <= col_eff;
              best_row_q <= row_eff;
            end
            if (last_i) begin
              rd_cnt_q <= '0;
              state_q  <= S_READ;
            end
          end
        end
        S_READ: begin
          rd_cnt_q <= rd_cnt_q + 3'd1;
          if (rd_cnt_q == 3'd4) begin
            axis_q  <= 1'b0;
            state_q <= S_START;
          end
        end
        S_START: state_q <= S_WAIT;
        S_WAIT: begin
          if (map_done) begin
            if (!axis_q) begin
              axis_q  <= 1'b1;
              state_q <= S_START;
            end else begin
              best_q     <= SAMPLE_MIN;
              best_col_q <= '0;
              best_row_q <= '0;
              col_q      <= '0;
              row_q      <= '0;
              state_q    <= S_SCAN;
            end
          end
        end
        default: state_q <= S_SCAN;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    // read data is registered in the ram, so each capture holds the word of the previous address
    if (state_q == S_READ && rd_cnt_q != 3'd0) begin
      nb_q[3] <= nb_q[2];
      nb_q[2] <= nb_q[1];
      nb_q[1] <= nb_q[0];
      nb_q[0] <= signed'(rdata);
    end
    if (state_q == S_WAIT && map_done && !axis_q) begin
      x_q <= map_res;
    end
    if (emit) begin
      y_q     <= map_res;
      score_q <= best_q;
      found_q <= found;
    end
  end

  assign done_o       = done_q;
  assign x_position_o = x_q;
  assign y_position_o = y_q;
  assign score_o      = score_q;
  assign found_o      = found_q;

endmodule
